// ===== hw/rtl/sbc_pkg.sv =====
package sbc_pkg;

    // Field widths
    localparam int CW   = 32;           // centers, times, results
    localparam int SW   = 24;           // box sizes
    localparam int VW   = 24;           // velocities
    localparam int FTW  = 16;           // frame time
    localparam int TFRAC = 16;          // time fraction bits
    localparam int FACEW = 3;

    // Internal widths
    localparam int EW   = 40;           // doubled-scale edge arithmetic
    localparam int PW   = VW + FTW;     // velocity times frame time
    localparam int RW   = VW + 1;       // absolute relative velocity
    localparam int LEN_SHIFT = 15;      // len * 65536 / (2 * rel) == len * 32768 / rel
    localparam int QW   = 50;           // quotient bits, one divider stage each
    localparam int TW   = QW + 1;       // signed contact time
    localparam int HPW  = VW + CW;      // velocity times hit time

    localparam logic [FTW-1:0] FRAME_TIME_RESET = 16'd1092;

    // Bit positions in the per-face hit vector
    localparam int HIT_TOP    = 0;
    localparam int HIT_BOTTOM = 1;
    localparam int HIT_LEFT   = 2;
    localparam int HIT_RIGHT  = 3;

    typedef enum logic [FACEW-1:0] {
        FACE_NONE   = 3'd0,
        FACE_TOP    = 3'd1,
        FACE_BOTTOM = 3'd2,
        FACE_LEFT   = 3'd3,
        FACE_RIGHT  = 3'd4
    } sbc_face_t;

    typedef logic signed [EW-1:0] sbc_edge_t;

    // Values that ride along with the division
    typedef struct packed {
        logic [CW-1:0] scx;
        logic [CW-1:0] scy;
        logic [VW-1:0] svx;
        logic [VW-1:0] svy;
        logic [3:0]    hit;
        logic          negx;
        logic          negy;
    } sbc_side_t;

    // One restoring divider lane: numerator shifts out, quotient shifts in
    typedef struct packed {
        logic [QW-1:0] num;
        logic [RW-1:0] rem;
        logic [RW-1:0] den;
    } sbc_lane_t;

    typedef struct packed {
        sbc_side_t side;
        sbc_lane_t lx;
        sbc_lane_t ly;
    } sbc_div_t;

    // Produce one quotient bit
    function automatic sbc_lane_t sbc_div_step(input sbc_lane_t a);
        sbc_lane_t   r;
        logic [RW:0] trial;
        logic        qb;
        trial = {a.rem, a.num[QW-1]};
        qb    = (trial >= {1'b0, a.den});
        r.den = a.den;
        r.rem = qb ? RW'(trial - {1'b0, a.den}) : RW'(trial);
        r.num = {a.num[QW-2:0], qb};
        return r;
    endfunction

    function automatic sbc_edge_t sbc_sx32(input logic [CW-1:0] v);
        return {{(EW-CW){v[CW-1]}}, v};
    endfunction

    function automatic sbc_edge_t sbc_sxv(input logic [VW-1:0] v);
        return {{(EW-VW){v[VW-1]}}, v};
    endfunction

    function automatic sbc_edge_t sbc_zxs(input logic [SW-1:0] v);
        return {{(EW-SW){1'b0}}, v};
    endfunction

    // Clamp a 64-bit two's complement value to the signed 32-bit range
    function automatic logic [CW-1:0] sbc_sat32(input logic [63:0] v);
        logic fits;
        fits = (v[63:CW-1] == '0) || (v[63:CW-1] == '1);
        if (fits) begin
            return v[CW-1:0];
        end else if (v[63]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

endpackage

// ===== hw/rtl/sbc_div_pipe.sv =====
module sbc_div_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbc_pkg::sbc_div_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sbc_pkg::sbc_div_t out_data
);
    import sbc_pkg::*;

    logic [QW-1:0] vld_reg;
    sbc_div_t      stage_reg [QW];
    sbc_div_t      stage_next [QW];
    logic [QW-1:0] src_vld;
    logic [QW:0]   rdy;

    // Each stage takes a transfer when it is empty or its successor moves
    always_comb begin
        rdy[QW] = out_ready;
        for (int k = QW - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign src_vld = {vld_reg[QW-2:0], in_valid};

    // One quotient bit per stage on both lanes
    always_comb begin
        stage_next[0]    = in_data;
        stage_next[0].lx = sbc_div_step(in_data.lx);
        stage_next[0].ly = sbc_div_step(in_data.ly);
        for (int k = 1; k < QW; k++) begin
            stage_next[k]    = stage_reg[k-1];
            stage_next[k].lx = sbc_div_step(stage_reg[k-1].lx);
            stage_next[k].ly = sbc_div_step(stage_reg[k-1].ly);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= src_vld[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QW; k++) begin
            if (rdy[k] && src_vld[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[QW-1];
    assign out_data  = stage_reg[QW-1];

endmodule

// ===== hw/rtl/swept_box_collision.sv =====
// Swept box collision test, streaming one box pair per cycle while s_ready is high.
// Input channel s_*: one transfer carries both boxes (center, size, velocity).
// Result channel m_*: one transfer per input, in input order, with the hit
// face, contact time and the first box center advanced to that time.
// cfg_wr_en/cfg_wr_data write frame_time; write it only while no pair is in
// flight.
// Pipeline: three front stages (frame motion multiply, edges, overlap tests),
// a 50-stage restoring divider that retires one quotient bit per stage for
// both axes, then face selection, the center multiply and the output
// register.
// Throughput: one pair per cycle while s_ready is high; every stage holds one
// pair and moves up when the stage after it is empty or moving, so internal
// bubbles are squeezed out. When the receiver stalls, results collect in the
// pipeline and s_ready drops only once every stage is full.
// Reset (synchronous, active low) empties the pipeline and sets frame_time
// to 1092.
module swept_box_collision (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [sbc_pkg::FTW-1:0]      cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [sbc_pkg::CW-1:0] s_self_center_x,
    input  logic signed [sbc_pkg::CW-1:0] s_self_center_y,
    input  logic [sbc_pkg::SW-1:0]       s_self_width,
    input  logic [sbc_pkg::SW-1:0]       s_self_height,
    input  logic signed [sbc_pkg::VW-1:0] s_self_vel_x,
    input  logic signed [sbc_pkg::VW-1:0] s_self_vel_y,
    input  logic signed [sbc_pkg::CW-1:0] s_other_center_x,
    input  logic signed [sbc_pkg::CW-1:0] s_other_center_y,
    input  logic [sbc_pkg::SW-1:0]       s_other_width,
    input  logic [sbc_pkg::SW-1:0]       s_other_height,
    input  logic signed [sbc_pkg::VW-1:0] s_other_vel_x,
    input  logic signed [sbc_pkg::VW-1:0] s_other_vel_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sbc_pkg::FACEW-1:0]    m_hit_face,
    output logic signed [sbc_pkg::CW-1:0] m_hit_time,
    output logic signed [sbc_pkg::CW-1:0] m_new_center_x,
    output logic signed [sbc_pkg::CW-1:0] m_new_center_y
);
    import sbc_pkg::*;

    typedef struct packed {
        logic [CW-1:0] scx, scy, ocx, ocy;
        logic [SW-1:0] sw, sh, ow, oh;
        logic [VW-1:0] svx, svy, ovx, ovy;
        logic [PW-1:0] psx, psy, pox, poy;
    } s1_t;

    typedef struct packed {
        sbc_edge_t s_left, s_right, s_bot, s_top;
        sbc_edge_t o_left, o_right, o_bot, o_top;
        sbc_edge_t a_left, a_right, a_bot, a_top;
        sbc_edge_t b_left, b_right, b_bot, b_top;
        sbc_edge_t lenx, leny;
        logic [RW-1:0] relx, rely;
        logic [CW-1:0] scx, scy;
        logic [VW-1:0] svx, svy;
    } s2_t;

    typedef struct packed {
        sbc_face_t     face;
        logic [CW-1:0] ht;
        logic [CW-1:0] scx, scy;
        logic [VW-1:0] svx, svy;
    } sel_t;

    typedef struct packed {
        sbc_face_t      face;
        logic [CW-1:0]  ht;
        logic [CW-1:0]  scx, scy;
        logic [HPW-1:0] px, py;
    } mul_t;

    logic [FTW-1:0] frame_time_reg;

    logic     s1_vld_reg, s2_vld_reg, s3_vld_reg, sel_vld_reg, mul_vld_reg, m_valid_reg;
    logic     s1_rdy, s2_rdy, s3_rdy, sel_rdy, mul_rdy, out_rdy;
    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    sbc_div_t s3_reg, s3_next;
    sel_t     sel_reg, sel_next;
    mul_t     mul_reg, mul_next;

    logic            div_in_ready, div_out_valid;
    sbc_div_t        div_out;

    sbc_face_t       m_face_reg;
    logic [CW-1:0]   m_time_reg, m_cx_reg, m_cy_reg;
    logic [CW-1:0]   m_cx_next, m_cy_next;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_time_reg <= FRAME_TIME_RESET;
        end else if (cfg_wr_en) begin
            frame_time_reg <= cfg_wr_data;
        end
    end

    // Stage handshake: take a transfer when empty or when the next stage moves
    assign out_rdy = !m_valid_reg || m_ready;
    assign mul_rdy = !mul_vld_reg || out_rdy;
    assign sel_rdy = !sel_vld_reg || mul_rdy;
    assign s3_rdy  = !s3_vld_reg || div_in_ready;
    assign s2_rdy  = !s2_vld_reg || s3_rdy;
    assign s1_rdy  = !s1_vld_reg || s2_rdy;
    assign s_ready = s1_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            sel_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_rdy)  s1_vld_reg  <= s_valid;
            if (s2_rdy)  s2_vld_reg  <= s1_vld_reg;
            if (s3_rdy)  s3_vld_reg  <= s2_vld_reg;
            if (sel_rdy) sel_vld_reg <= div_out_valid;
            if (mul_rdy) mul_vld_reg <= sel_vld_reg;
            if (out_rdy) m_valid_reg <= mul_vld_reg;
        end
    end

    // Stage 1: frame displacement products
    logic signed [FTW:0] ft_s;
    logic signed [PW:0]  pr_sx, pr_sy, pr_ox, pr_oy;

    assign ft_s  = $signed({1'b0, frame_time_reg});
    assign pr_sx = s_self_vel_x * ft_s;
    assign pr_sy = s_self_vel_y * ft_s;
    assign pr_ox = s_other_vel_x * ft_s;
    assign pr_oy = s_other_vel_y * ft_s;

    always_comb begin
        s1_next.scx = s_self_center_x;
        s1_next.scy = s_self_center_y;
        s1_next.ocx = s_other_center_x;
        s1_next.ocy = s_other_center_y;
        s1_next.sw  = s_self_width;
        s1_next.sh  = s_self_height;
        s1_next.ow  = s_other_width;
        s1_next.oh  = s_other_height;
        s1_next.svx = s_self_vel_x;
        s1_next.svy = s_self_vel_y;
        s1_next.ovx = s_other_vel_x;
        s1_next.ovy = s_other_vel_y;
        s1_next.psx = pr_sx[PW-1:0];
        s1_next.psy = pr_sy[PW-1:0];
        s1_next.pox = pr_ox[PW-1:0];
        s1_next.poy = pr_oy[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && s_valid) s1_reg <= s1_next;
    end

    // Stage 2: doubled-scale edges at start and after the frame, gap lengths, relative speeds
    always_comb begin
        sbc_edge_t scx2, scy2, ocx2, ocy2;
        sbc_edge_t sdx2, sdy2, odx2, ody2;
        sbc_edge_t dx, dy, rvx, rvy, ax, ay;

        scx2 = sbc_sx32(s1_reg.scx) + sbc_sx32(s1_reg.scx);
        scy2 = sbc_sx32(s1_reg.scy) + sbc_sx32(s1_reg.scy);
        ocx2 = sbc_sx32(s1_reg.ocx) + sbc_sx32(s1_reg.ocx);
        ocy2 = sbc_sx32(s1_reg.ocy) + sbc_sx32(s1_reg.ocy);
        // floor of product / 65536 is the upper slice
        sdx2 = sbc_sxv(s1_reg.psx[PW-1:TFRAC]) + sbc_sxv(s1_reg.psx[PW-1:TFRAC]);
        sdy2 = sbc_sxv(s1_reg.psy[PW-1:TFRAC]) + sbc_sxv(s1_reg.psy[PW-1:TFRAC]);
        odx2 = sbc_sxv(s1_reg.pox[PW-1:TFRAC]) + sbc_sxv(s1_reg.pox[PW-1:TFRAC]);
        ody2 = sbc_sxv(s1_reg.poy[PW-1:TFRAC]) + sbc_sxv(s1_reg.poy[PW-1:TFRAC]);

        s2_next.s_left  = scx2 - sbc_zxs(s1_reg.sw);
        s2_next.s_right = scx2 + sbc_zxs(s1_reg.sw);
        s2_next.s_bot   = scy2 - sbc_zxs(s1_reg.sh);
        s2_next.s_top   = scy2 + sbc_zxs(s1_reg.sh);
        s2_next.o_left  = ocx2 - sbc_zxs(s1_reg.ow);
        s2_next.o_right = ocx2 + sbc_zxs(s1_reg.ow);
        s2_next.o_bot   = ocy2 - sbc_zxs(s1_reg.oh);
        s2_next.o_top   = ocy2 + sbc_zxs(s1_reg.oh);
        s2_next.a_left  = scx2 + sdx2 - sbc_zxs(s1_reg.sw);
        s2_next.a_right = scx2 + sdx2 + sbc_zxs(s1_reg.sw);
        s2_next.a_bot   = scy2 + sdy2 - sbc_zxs(s1_reg.sh);
        s2_next.a_top   = scy2 + sdy2 + sbc_zxs(s1_reg.sh);
        s2_next.b_left  = ocx2 + odx2 - sbc_zxs(s1_reg.ow);
        s2_next.b_right = ocx2 + odx2 + sbc_zxs(s1_reg.ow);
        s2_next.b_bot   = ocy2 + ody2 - sbc_zxs(s1_reg.oh);
        s2_next.b_top   = ocy2 + ody2 + sbc_zxs(s1_reg.oh);

        dx = scx2 - ocx2;
        dy = scy2 - ocy2;
        ax = dx[EW-1] ? -dx : dx;
        ay = dy[EW-1] ? -dy : dy;
        s2_next.lenx = ax - sbc_zxs(s1_reg.sw) - sbc_zxs(s1_reg.ow);
        s2_next.leny = ay - sbc_zxs(s1_reg.sh) - sbc_zxs(s1_reg.oh);

        rvx = sbc_sxv(s1_reg.svx) - sbc_sxv(s1_reg.ovx);
        rvy = sbc_sxv(s1_reg.svy) - sbc_sxv(s1_reg.ovy);
        s2_next.relx = rvx[EW-1] ? RW'(-rvx) : RW'(rvx);
        s2_next.rely = rvy[EW-1] ? RW'(-rvy) : RW'(rvy);

        s2_next.scx = s1_reg.scx;
        s2_next.scy = s1_reg.scy;
        s2_next.svx = s1_reg.svx;
        s2_next.svy = s1_reg.svy;
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy && s1_vld_reg) s2_reg <= s2_next;
    end

    // Stage 3: corner containment, gap sign flips, divider operands
    function automatic logic corner_in(input sbc_edge_t px, input sbc_edge_t py,
                                       input s2_t e);
        return px >= e.b_left && px <= e.b_right && py >= e.b_bot && py <= e.b_top;
    endfunction

    function automatic logic gap_flip(input sbc_edge_t g0, input sbc_edge_t g1);
        logic n0, p0, n1, p1;
        n0 = g0[EW-1];
        p0 = !g0[EW-1] && (g0 != '0);
        n1 = g1[EW-1];
        p1 = !g1[EW-1] && (g1 != '0);
        return (n0 && p1) || (p0 && n1);
    endfunction

    always_comb begin
        logic in_lb, in_rb, in_lt, in_rt;
        logic rx_nz, ry_nz;
        sbc_edge_t magx, magy;

        in_lb = corner_in(s2_reg.a_left,  s2_reg.a_bot, s2_reg);
        in_rb = corner_in(s2_reg.a_right, s2_reg.a_bot, s2_reg);
        in_lt = corner_in(s2_reg.a_left,  s2_reg.a_top, s2_reg);
        in_rt = corner_in(s2_reg.a_right, s2_reg.a_top, s2_reg);
        rx_nz = (s2_reg.relx != '0);
        ry_nz = (s2_reg.rely != '0);

        s3_next.side.hit[HIT_TOP] = (in_lb || in_rb) && ry_nz &&
            gap_flip(s2_reg.s_bot - s2_reg.o_top, s2_reg.a_bot - s2_reg.b_top);
        s3_next.side.hit[HIT_BOTTOM] = (in_lt || in_rt) && ry_nz &&
            gap_flip(s2_reg.s_top - s2_reg.o_bot, s2_reg.a_top - s2_reg.b_bot);
        s3_next.side.hit[HIT_LEFT] = (in_lb || in_lt) && rx_nz &&
            gap_flip(s2_reg.s_left - s2_reg.o_right, s2_reg.a_left - s2_reg.b_right);
        s3_next.side.hit[HIT_RIGHT] = (in_rb || in_rt) && rx_nz &&
            gap_flip(s2_reg.s_right - s2_reg.o_left, s2_reg.a_right - s2_reg.b_left);

        s3_next.side.negx = s2_reg.lenx[EW-1];
        s3_next.side.negy = s2_reg.leny[EW-1];
        s3_next.side.scx  = s2_reg.scx;
        s3_next.side.scy  = s2_reg.scy;
        s3_next.side.svx  = s2_reg.svx;
        s3_next.side.svy  = s2_reg.svy;

        magx = s2_reg.lenx[EW-1] ? -s2_reg.lenx : s2_reg.lenx;
        magy = s2_reg.leny[EW-1] ? -s2_reg.leny : s2_reg.leny;
        s3_next.lx.num = QW'({magx, {LEN_SHIFT{1'b0}}});
        s3_next.ly.num = QW'({magy, {LEN_SHIFT{1'b0}}});
        s3_next.lx.rem = '0;
        s3_next.ly.rem = '0;
        s3_next.lx.den = s2_reg.relx;
        s3_next.ly.den = s2_reg.rely;
    end

    always_ff @(posedge aclk) begin
        if (s3_rdy && s2_vld_reg) s3_reg <= s3_next;
    end

    sbc_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s3_vld_reg),
        .in_ready  (div_in_ready),
        .in_data   (s3_reg),
        .out_valid (div_out_valid),
        .out_ready (sel_rdy),
        .out_data  (div_out)
    );

    // Select the earliest face; ties keep the face tested first
    always_comb begin
        logic signed [TW-1:0] ux, uy, tx, ty, best;
        logic [FTW+1:0]       limit;

        ux    = $signed({1'b0, div_out.lx.num});
        uy    = $signed({1'b0, div_out.ly.num});
        tx    = div_out.side.negx ? -ux : ux;
        ty    = div_out.side.negy ? -uy : uy;
        limit = {2'b00, frame_time_reg} + (FTW+2)'(1 << TFRAC);
        best  = $signed({{(TW-FTW-2){1'b0}}, limit});

        sel_next.face = FACE_NONE;
        if (div_out.side.hit[HIT_TOP] && ty < best) begin
            best = ty;
            sel_next.face = FACE_TOP;
        end
        if (div_out.side.hit[HIT_BOTTOM] && ty < best) begin
            best = ty;
            sel_next.face = FACE_BOTTOM;
        end
        if (div_out.side.hit[HIT_LEFT] && tx < best) begin
            best = tx;
            sel_next.face = FACE_LEFT;
        end
        if (div_out.side.hit[HIT_RIGHT] && tx < best) begin
            best = tx;
            sel_next.face = FACE_RIGHT;
        end

        if (sel_next.face == FACE_NONE) begin
            sel_next.ht = '0;
        end else begin
            sel_next.ht = sbc_sat32({{(64-TW){best[TW-1]}}, best});
        end
        sel_next.scx = div_out.side.scx;
        sel_next.scy = div_out.side.scy;
        sel_next.svx = div_out.side.svx;
        sel_next.svy = div_out.side.svy;
    end

    always_ff @(posedge aclk) begin
        if (sel_rdy && div_out_valid) sel_reg <= sel_next;
    end

    // Advance the first center: velocity times contact time
    logic signed [HPW-1:0] px_c, py_c;

    assign px_c = $signed(sel_reg.svx) * $signed(sel_reg.ht);
    assign py_c = $signed(sel_reg.svy) * $signed(sel_reg.ht);

    always_comb begin
        mul_next.face = sel_reg.face;
        mul_next.ht   = sel_reg.ht;
        mul_next.scx  = sel_reg.scx;
        mul_next.scy  = sel_reg.scy;
        mul_next.px   = px_c;
        mul_next.py   = py_c;
    end

    always_ff @(posedge aclk) begin
        if (mul_rdy && sel_vld_reg) mul_reg <= mul_next;
    end

    // Add the floored displacement and saturate
    always_comb begin
        logic [63:0] sx, sy;
        sx = {{(64-HPW+TFRAC){mul_reg.px[HPW-1]}}, mul_reg.px[HPW-1:TFRAC]}
           + {{(64-CW){mul_reg.scx[CW-1]}}, mul_reg.scx};
        sy = {{(64-HPW+TFRAC){mul_reg.py[HPW-1]}}, mul_reg.py[HPW-1:TFRAC]}
           + {{(64-CW){mul_reg.scy[CW-1]}}, mul_reg.scy};
        m_cx_next = sbc_sat32(sx);
        m_cy_next = sbc_sat32(sy);
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && mul_vld_reg) begin
            m_face_reg <= mul_reg.face;
            m_time_reg <= mul_reg.ht;
            m_cx_reg   <= m_cx_next;
            m_cy_reg   <= m_cy_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit_face     = m_face_reg;
    assign m_hit_time     = m_time_reg;
    assign m_new_center_x = m_cx_reg;
    assign m_new_center_y = m_cy_reg;

`ifndef NO_ASSERTIONS
    // Face code stays within the defined faces
    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hit_face <= FACE_RIGHT))
        else $error("hit face out of range");

    // A miss reports zero time
    a_miss_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit_face == FACE_NONE) |-> (m_hit_time == '0))
        else $error("miss with nonzero hit time");

    // A hit lies before frame time plus one second
    a_hit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_hit_face != FACE_NONE) |->
            ($signed(m_hit_time) < $signed({{(CW-FTW-2){1'b0}}, 2'b01, frame_time_reg})))
        else $error("hit time beyond start bound");

    // Input backpressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
